### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation package
// Shared widths and the calibration register indices of the compensation
// pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Temperature divider: |MC * 2048| over |X1 + MD|.
  localparam int TDIV_DVD_W  = 27;
  localparam int TDIV_DVS_W  = 19;
  localparam int TDIV_SIDE_W = 37;

  // Pressure divider: scaled B7 over B4.
  localparam int PDIV_DVD_W  = 32;
  localparam int PDIV_DVS_W  = 17;
  localparam int PDIV_SIDE_W = 18;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Calibration register indices.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AC1_AC2 = 3'd0,
    CFG_AC3_AC4 = 3'd1,
    CFG_AC5_AC6 = 3'd2,
    CFG_B1_B2   = 3'd3,
    CFG_MC_MD   = 3'd4
  } cfg_idx_t;

endpackage

### rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division, one quotient bit per register stage, with a sideband
// word and a valid bit that travel alongside each operand pair.
// ----------------------------------------------------------------------------
module bpc_div #(
  parameter int DVD_W  = bpc_pkg::PDIV_DVD_W,
  parameter int DVS_W  = bpc_pkg::PDIV_DVS_W,
  parameter int SIDE_W = bpc_pkg::PDIV_SIDE_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [DVD_W-1:0]  in_dividend,
  input  logic [DVS_W-1:0]  in_divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [DVD_W-1:0]  out_quotient,
  output logic [SIDE_W-1:0] out_side
);

  // Stage registers; the dividend shifts out at the top while quotient
  // bits shift in at the bottom.
  logic              vld_r  [DVD_W];
  logic [DVD_W-1:0]  acc_r  [DVD_W];
  logic [DVS_W-1:0]  rem_r  [DVD_W];
  logic [DVS_W-1:0]  dvs_r  [DVD_W];
  logic [SIDE_W-1:0] side_r [DVD_W];

  for (genvar s = 0; s < DVD_W; s++) begin : g_stage
    logic              vld_in;
    logic [DVD_W-1:0]  acc_in;
    logic [DVS_W-1:0]  rem_in;
    logic [DVS_W-1:0]  dvs_in;
    logic [SIDE_W-1:0] side_in;
    logic [DVS_W:0]    trial;
    logic [DVS_W+1:0]  diff;
    logic              fit;
    logic [DVS_W-1:0]  rem_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_vld;
      assign acc_in  = in_dividend;
      assign rem_in  = '0;
      assign dvs_in  = in_divisor;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign acc_in  = acc_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign dvs_in  = dvs_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
      trial   = {rem_in, acc_in[DVD_W-1]};
      diff    = {1'b0, trial} - {2'b00, dvs_in};
      fit     = ~diff[DVS_W+1];
      rem_nxt = fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      acc_r[s]  <= {acc_in[DVD_W-2:0], fit};
      rem_r[s]  <= rem_nxt;
      dvs_r[s]  <= dvs_in;
      side_r[s] <= side_in;
    end
  end

  assign out_vld      = vld_r[DVD_W-1];
  assign out_quotient = acc_r[DVD_W-1];
  assign out_side     = side_r[DVD_W-1];

endmodule

### rtl/barometric_pressure_compensation_unit.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation unit
// Integer temperature and pressure compensation of a digital barometer at
// oversampling 0, built as a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
// - Calibration is written through cfg_we / cfg_index / cfg_wdata, one
//   32-bit word per beat, while no reading is in flight. Unknown indices are
//   ignored. Reset clears all calibration words to zero.
// - A reading pair is accepted on a clock edge with start high and busy low.
//   busy is held low: one beat can be accepted on every clock cycle.
// - Each result appears on the out_ ports for exactly one cycle, marked by
//   out_valid. The path runs through the two pipelined dividers (27 and 32
//   stages) and the 17 arithmetic stages around them.
// - The receiver cannot stall the block; results are never held back.
// - out_divide_fault is high when either divisor was zero; the other result
//   fields are then zero.
// - Synchronous active-low reset empties the pipeline; no result is
//   produced for readings in flight at reset.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [15:0]                      in_raw_temperature,
  input  logic [15:0]                      in_raw_pressure,
  output logic                             out_valid,
  output logic signed [15:0]               out_temperature_decidegrees,
  output logic [19:0]                      out_pressure_pascal,
  output logic [16:0]                      out_pressure_mmhg_tenths,
  output logic                             out_divide_fault,
  input  logic                             cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int TDW = bpc_pkg::TDIV_DVD_W;
  localparam int TSW = bpc_pkg::TDIV_DVS_W;
  localparam int TXW = bpc_pkg::TDIV_SIDE_W;
  localparam int PDW = bpc_pkg::PDIV_DVD_W;
  localparam int PSW = bpc_pkg::PDIV_DVS_W;
  localparam int PXW = bpc_pkg::PDIV_SIDE_W;

  // Calibration registers.
  logic [31:0] cal_ac12_r, cal_ac34_r, cal_ac56_r, cal_b12_r, cal_mcmd_r;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  // Stage registers.
  logic                st1_vld_r, st2_vld_r, st3_vld_r;
  logic signed [33:0]  st1_prod_r;
  logic [15:0]         st1_up_r, st2_up_r, st3_up_r;
  logic signed [18:0]  st2_x1_r, st3_x1_r;
  logic signed [19:0]  st2_den_r;
  logic [TDW-1:0]      st3_num_r;
  logic [TSW-1:0]      st3_den_r;
  logic                st3_neg_r, st3_fault_r;

  logic                td_vld;
  logic [TDW-1:0]      td_q;
  logic [TXW-1:0]      td_side;
  logic signed [18:0]  td_x1;

  logic                st4_vld_r, st5_vld_r, st6_vld_r, st7_vld_r;
  logic                st8_vld_r, st9_vld_r, st10_vld_r, st11_vld_r;
  logic signed [28:0]  st4_b5_r;
  logic signed [28:0]  st5_b6_r;
  logic signed [15:0]  st5_t_r, st6_t_r, st7_t_r, st8_t_r, st9_t_r, st10_t_r, st11_t_r;
  logic [15:0]         st4_up_r, st5_up_r, st6_up_r, st7_up_r, st8_up_r, st9_up_r;
  logic                st4_fault_r, st5_fault_r, st6_fault_r, st7_fault_r;
  logic                st8_fault_r, st9_fault_r, st10_fault_r, st11_fault_r;
  logic signed [57:0]  st6_sq_r;
  logic signed [44:0]  st6_ac2b6_r, st7_ac2b6_r, st8_ac2b6_r;
  logic signed [44:0]  st6_ac3b6_r, st7_ac3b6_r, st8_ac3b6_r;
  logic signed [37:0]  st7_b2lo_r, st7_b2hi_r, st7_b1lo_r, st7_b1hi_r;
  logic signed [49:0]  st8_pb2_r, st8_pb1_r;
  logic [31:0]         st9_b3_r, st9_x3p_r;
  logic [31:0]         st10_b7a_r, st11_b7_r;
  logic [PSW-1:0]      st10_b4_r, st11_b4_r;

  logic                pd_vld;
  logic [PDW-1:0]      pd_q;
  logic [PXW-1:0]      pd_side;
  logic [PDW-1:0]      pd_dividend;

  logic                st12_vld_r, st13_vld_r, st14_vld_r, st15_vld_r, st16_vld_r;
  logic signed [15:0]  st12_t_r, st13_t_r, st14_t_r, st15_t_r, st16_t_r;
  logic                st12_fault_r, st13_fault_r, st14_fault_r, st15_fault_r;
  logic                st16_fault_r;
  logic [32:0]         st12_pq_r, st13_pq_r, st14_pq_r;
  logic [49:0]         st12_sq2_r;
  logic [45:0]         st12_m2_r;
  logic [45:0]         st13_x1c_r;
  logic signed [31:0]  st13_x2c_r;
  logic signed [47:0]  st14_s_r;
  logic [19:0]         st15_psat_r, st16_psat_r;
  logic [18:0]         st16_v_r;

  logic                out_valid_r;
  logic signed [15:0]  out_t_r;
  logic [19:0]         out_p_r;
  logic [16:0]         out_mm_r;
  logic                out_fault_r;

  // Combinational next values.
  logic signed [16:0]  st1_diff;
  logic signed [33:0]  st1_prod_nxt;
  logic signed [18:0]  st2_x1_nxt;
  logic signed [19:0]  st2_den_nxt;
  logic [15:0]         mc_abs;
  logic [TSW-1:0]      st3_den_nxt;
  logic signed [28:0]  st4_b5_nxt;
  logic signed [28:0]  st5_tt;
  logic signed [15:0]  st5_t_nxt;
  logic [41:0]         b6sq;
  logic [33:0]         st9_sum, st9_sump;
  logic [31:0]         x3b;
  logic [47:0]         b4_prod, b7_prod;
  logic [61:0]         x1_prod;
  logic signed [47:0]  neg_m2;
  logic signed [48:0]  pf;
  logic [19:0]         st15_psat_nxt;
  logic [21:0]         three_p;
  logic [38:0]         mm_prod;

  assign busy = 1'b0;

  // Calibration writes; indices outside the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_ac12_r <= '0;
      cal_ac34_r <= '0;
      cal_ac56_r <= '0;
      cal_b12_r  <= '0;
      cal_mcmd_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::CFG_AC1_AC2: cal_ac12_r <= cfg_wdata;
        bpc_pkg::CFG_AC3_AC4: cal_ac34_r <= cfg_wdata;
        bpc_pkg::CFG_AC5_AC6: cal_ac56_r <= cfg_wdata;
        bpc_pkg::CFG_B1_B2:   cal_b12_r  <= cfg_wdata;
        bpc_pkg::CFG_MC_MD:   cal_mcmd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack the calibration words.
  assign ac1 = cal_ac12_r[31:16];
  assign ac2 = cal_ac12_r[15:0];
  assign ac3 = cal_ac34_r[31:16];
  assign ac4 = cal_ac34_r[15:0];
  assign ac5 = cal_ac56_r[31:16];
  assign ac6 = cal_ac56_r[15:0];
  assign b1  = cal_b12_r[31:16];
  assign b2  = cal_b12_r[15:0];
  assign mc  = cal_mcmd_r[31:16];
  assign md  = cal_mcmd_r[15:0];

  // Temperature front end: X1 product, divisor and operand magnitudes.
  always_comb begin
    st1_diff     = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, ac6});
    st1_prod_nxt = st1_diff * $signed({1'b0, ac5});
    st2_x1_nxt   = st1_prod_r[33:15];
    st2_den_nxt  = 20'(st2_x1_nxt) + 20'(md);
    mc_abs       = mc[15] ? 16'(-mc) : mc;
    st3_den_nxt  = st2_den_r[19] ? TSW'(-st2_den_r) : TSW'(st2_den_r);
  end

  always_ff @(posedge clk) begin
    st1_prod_r  <= st1_prod_nxt;
    st1_up_r    <= in_raw_pressure;
    st2_x1_r    <= st2_x1_nxt;
    st2_den_r   <= st2_den_nxt;
    st2_up_r    <= st1_up_r;
    st3_num_r   <= {mc_abs, 11'd0};
    st3_den_r   <= st3_den_nxt;
    st3_neg_r   <= mc[15] ^ st2_den_r[19];
    st3_fault_r <= (st2_den_r == '0);
    st3_x1_r    <= st2_x1_r;
    st3_up_r    <= st2_up_r;
  end

  // Temperature division: MC * 2048 / (X1 + MD), magnitudes only.
  bpc_div #(
    .DVD_W  (TDW),
    .DVS_W  (TSW),
    .SIDE_W (TXW)
  ) u_tdiv (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (st3_vld_r),
    .in_dividend  (st3_num_r),
    .in_divisor   (st3_den_r),
    .in_side      ({st3_fault_r, st3_neg_r, st3_x1_r, st3_up_r}),
    .out_vld      (td_vld),
    .out_quotient (td_q),
    .out_side     (td_side)
  );

  assign td_x1 = td_side[34:16];

  // B5, then temperature and B6.
  always_comb begin
    st4_b5_nxt = td_side[35] ? 29'(td_x1) - $signed({2'b00, td_q})
                             : 29'(td_x1) + $signed({2'b00, td_q});
    st5_tt     = (st4_b5_r + 29'sd8) >>> 4;
    if (st5_tt > 29'sd32767) begin
      st5_t_nxt = 16'sh7FFF;
    end else if (st5_tt < -29'sd32768) begin
      st5_t_nxt = 16'sh8000;
    end else begin
      st5_t_nxt = st5_tt[15:0];
    end
    b6sq = st6_sq_r[53:12];
  end

  always_ff @(posedge clk) begin
    st4_b5_r    <= st4_b5_nxt;
    st4_up_r    <= td_side[15:0];
    st4_fault_r <= td_side[36];
    st5_b6_r    <= st4_b5_r - 29'sd4000;
    st5_t_r     <= st5_t_nxt;
    st5_up_r    <= st4_up_r;
    st5_fault_r <= st4_fault_r;
    // B6 products.
    st6_sq_r    <= st5_b6_r * st5_b6_r;
    st6_ac2b6_r <= ac2 * st5_b6_r;
    st6_ac3b6_r <= ac3 * st5_b6_r;
    st6_t_r     <= st5_t_r;
    st6_up_r    <= st5_up_r;
    st6_fault_r <= st5_fault_r;
    // B6 squared split in halves against B2 and B1.
    st7_b2lo_r  <= b2 * $signed({1'b0, b6sq[20:0]});
    st7_b2hi_r  <= b2 * $signed({1'b0, b6sq[41:21]});
    st7_b1lo_r  <= b1 * $signed({1'b0, b6sq[20:0]});
    st7_b1hi_r  <= b1 * $signed({1'b0, b6sq[41:21]});
    st7_ac2b6_r <= st6_ac2b6_r;
    st7_ac3b6_r <= st6_ac3b6_r;
    st7_t_r     <= st6_t_r;
    st7_up_r    <= st6_up_r;
    st7_fault_r <= st6_fault_r;
    // Recombine partial products; only the low 50 bits are ever used.
    st8_pb2_r   <= (50'(st7_b2hi_r) <<< 21) + 50'(st7_b2lo_r);
    st8_pb1_r   <= (50'(st7_b1hi_r) <<< 21) + 50'(st7_b1lo_r);
    st8_ac2b6_r <= st7_ac2b6_r;
    st8_ac3b6_r <= st7_ac3b6_r;
    st8_t_r     <= st7_t_r;
    st8_up_r    <= st7_up_r;
    st8_fault_r <= st7_fault_r;
  end

  // B3 and the B4 term. Both feed 32-bit wrapping arithmetic, so the sums
  // are kept modulo 2^34 and the floor shifts become plain bit slices.
  always_comb begin
    st9_sum  = 34'($signed({ac1, 2'b00})) + st8_pb2_r[44:11] + st8_ac2b6_r[44:11] + 34'd2;
    st9_sump = 34'($signed(st8_ac3b6_r[44:13])) + st8_pb1_r[49:16] + 34'd2;
    x3b      = st9_x3p_r + 32'd32768;
    b4_prod  = ac4 * x3b;
    b7_prod  = st10_b7a_r * 16'd50000;
  end

  always_ff @(posedge clk) begin
    st9_b3_r     <= st9_sum[33:2];
    st9_x3p_r    <= st9_sump[33:2];
    st9_t_r      <= st8_t_r;
    st9_up_r     <= st8_up_r;
    st9_fault_r  <= st8_fault_r;
    st10_b4_r    <= b4_prod[31:15];
    st10_b7a_r   <= {16'd0, st9_up_r} - st9_b3_r;
    st10_t_r     <= st9_t_r;
    st10_fault_r <= st9_fault_r;
    st11_b7_r    <= b7_prod[31:0];
    st11_b4_r    <= st10_b4_r;
    st11_t_r     <= st10_t_r;
    st11_fault_r <= st10_fault_r | (st10_b4_r == '0);
  end

  // Large B7 is divided first and doubled after; otherwise doubled first.
  assign pd_dividend = st11_b7_r[31] ? st11_b7_r : {st11_b7_r[30:0], 1'b0};

  bpc_div #(
    .DVD_W  (PDW),
    .DVS_W  (PSW),
    .SIDE_W (PXW)
  ) u_pdiv (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (st11_vld_r),
    .in_dividend  (pd_dividend),
    .in_divisor   (st11_b4_r),
    .in_side      ({st11_t_r, st11_fault_r, st11_b7_r[31]}),
    .out_vld      (pd_vld),
    .out_quotient (pd_q),
    .out_side     (pd_side)
  );

  // Final pressure polynomial, saturation and mmHg scaling.
  always_comb begin
    // 3038 = 2048 + 1024 - 32 - 2.
    x1_prod = 62'({st12_sq2_r, 11'd0}) + 62'({st12_sq2_r, 10'd0})
            - 62'({st12_sq2_r, 5'd0}) - 62'({st12_sq2_r, 1'b0});
    neg_m2  = -$signed({2'b00, st12_m2_r});
    pf      = $signed({16'd0, st14_pq_r}) + 49'(st14_s_r >>> 4);
    if (pf < 49'sd0) begin
      st15_psat_nxt = '0;
    end else if (pf > 49'sd1048575) begin
      st15_psat_nxt = 20'hFFFFF;
    end else begin
      st15_psat_nxt = pf[19:0];
    end
    three_p = {2'b00, st15_psat_r} + {1'b0, st15_psat_r, 1'b0};
    // Division by 5 through a reciprocal, exact for values below 2^19.
    mm_prod = st16_v_r * 20'd838861;
  end

  always_ff @(posedge clk) begin
    st12_pq_r    <= pd_side[0] ? {pd_q, 1'b0} : {1'b0, pd_q};
    st12_t_r     <= pd_side[17:2];
    st12_fault_r <= pd_side[1];
    st12_sq2_r   <= (pd_side[0] ? pd_q[31:7] : pd_q[32-1:8]) * 
                    (pd_side[0] ? pd_q[31:7] : pd_q[32-1:8]);
    st12_m2_r    <= (pd_side[0] ? {pd_q, 1'b0} : {1'b0, pd_q}) * 13'd7357;
    st13_x1c_r   <= x1_prod[61:16];
    st13_x2c_r   <= neg_m2[47:16];
    st13_pq_r    <= st12_pq_r;
    st13_t_r     <= st12_t_r;
    st13_fault_r <= st12_fault_r;
    st14_s_r     <= $signed({2'b00, st13_x1c_r}) + 48'(st13_x2c_r) + 48'sd3791;
    st14_pq_r    <= st13_pq_r;
    st14_t_r     <= st13_t_r;
    st14_fault_r <= st13_fault_r;
    st15_psat_r  <= st15_psat_nxt;
    st15_t_r     <= st14_t_r;
    st15_fault_r <= st14_fault_r;
    st16_v_r     <= three_p[21:3];
    st16_psat_r  <= st15_psat_r;
    st16_t_r     <= st15_t_r;
    st16_fault_r <= st15_fault_r;
    // Output register; a divide fault forces every field but the fault flag to zero.
    out_t_r      <= st16_fault_r ? 16'sd0 : st16_t_r;
    out_p_r      <= st16_fault_r ? 20'd0 : st16_psat_r;
    out_mm_r     <= st16_fault_r ? 17'd0 : mm_prod[38:22];
    out_fault_r  <= st16_fault_r;
  end

  // Valid bits travelling with each beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r   <= 1'b0;
      st2_vld_r   <= 1'b0;
      st3_vld_r   <= 1'b0;
      st4_vld_r   <= 1'b0;
      st5_vld_r   <= 1'b0;
      st6_vld_r   <= 1'b0;
      st7_vld_r   <= 1'b0;
      st8_vld_r   <= 1'b0;
      st9_vld_r   <= 1'b0;
      st10_vld_r  <= 1'b0;
      st11_vld_r  <= 1'b0;
      st12_vld_r  <= 1'b0;
      st13_vld_r  <= 1'b0;
      st14_vld_r  <= 1'b0;
      st15_vld_r  <= 1'b0;
      st16_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st1_vld_r   <= start & ~busy;
      st2_vld_r   <= st1_vld_r;
      st3_vld_r   <= st2_vld_r;
      st4_vld_r   <= td_vld;
      st5_vld_r   <= st4_vld_r;
      st6_vld_r   <= st5_vld_r;
      st7_vld_r   <= st6_vld_r;
      st8_vld_r   <= st7_vld_r;
      st9_vld_r   <= st8_vld_r;
      st10_vld_r  <= st9_vld_r;
      st11_vld_r  <= st10_vld_r;
      st12_vld_r  <= pd_vld;
      st13_vld_r  <= st12_vld_r;
      st14_vld_r  <= st13_vld_r;
      st15_vld_r  <= st14_vld_r;
      st16_vld_r  <= st15_vld_r;
      out_valid_r <= st16_vld_r;
    end
  end

  assign out_valid                   = out_valid_r;
  assign out_temperature_decidegrees = out_t_r;
  assign out_pressure_pascal         = out_p_r;
  assign out_pressure_mmhg_tenths    = out_mm_r;
  assign out_divide_fault            = out_fault_r;

endmodule

### test/barometric_pressure_compensation_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric pressure compensation unit testbench
// A table of directed readings and calibration writes is followed by random
// phases, each with its own calibration set and sender idle rate. Every
// accepted reading pair is predicted in the testbench. Each result beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_unit_tb;

  localparam int LATENCY = 75;
  localparam int IDX_W   = bpc_pkg::CFG_IDX_W;
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [15:0] temp;
    logic [19:0] pascal;
    logic [16:0] mmhg;
    logic        fault;
  } reading_t;

  // Either a calibration write or a reading pair, with an optional typed result.
  typedef struct {
    bit                  wr;
    bit [IDX_W-1:0]      idx;
    bit [31:0]           data;
    bit [15:0]           ut;
    bit [15:0]           up;
    bit                  typed;
    reading_t            res;
  } row_t;

  typedef struct {
    bit       typed;
    reading_t res;
  } override_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_raw_temperature;
  logic [15:0] in_raw_pressure;
  logic        out_valid;
  logic signed [15:0] out_temperature_decidegrees;
  logic [19:0] out_pressure_pascal;
  logic [16:0] out_pressure_mmhg_tenths;
  logic        out_divide_fault;
  logic        cfg_we;
  logic [IDX_W-1:0]                cfg_index;
  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  bit [31:0]  cal [0:4];
  reading_t   pending_readings [$];
  override_t  typed_results [$];
  int         errors;
  int         beats_in;
  int         beats_out;
  int         faults_seen;

  barometric_pressure_compensation_unit u_top (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .start                       (start),
    .busy                        (busy),
    .in_raw_temperature          (in_raw_temperature),
    .in_raw_pressure             (in_raw_pressure),
    .out_valid                   (out_valid),
    .out_temperature_decidegrees (out_temperature_decidegrees),
    .out_pressure_pascal         (out_pressure_pascal),
    .out_pressure_mmhg_tenths    (out_pressure_mmhg_tenths),
    .out_divide_fault            (out_divide_fault),
    .cfg_we                      (cfg_we),
    .cfg_index                   (cfg_index),
    .cfg_wdata                   (cfg_wdata)
  );

  // 8 ns clock.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Compensation of one reading pair with the current calibration words.
  function automatic reading_t compensate(bit [15:0] raw_t, bit [15:0] raw_p);
    longint   ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint   ut, up, x1, x2, x3, b5, tc, b6, b6sq, b3, p;
    bit [31:0] b4, b7;
    bit [63:0] wide;
    reading_t r;
    ac1 = longint'($signed(cal[0][31:16]));
    ac2 = longint'($signed(cal[0][15:0]));
    ac3 = longint'($signed(cal[1][31:16]));
    ac4 = longint'(cal[1][15:0]);
    ac5 = longint'(cal[2][31:16]);
    ac6 = longint'(cal[2][15:0]);
    b1  = longint'($signed(cal[3][31:16]));
    b2  = longint'($signed(cal[3][15:0]));
    mc  = longint'($signed(cal[4][31:16]));
    md  = longint'($signed(cal[4][15:0]));
    ut  = longint'(raw_t);
    up  = longint'(raw_p);
    r = '0;
    r.fault = 1'b1;

    // Temperature.
    x1 = ((ut - ac6) * ac5) >>> 15;
    if (x1 + md == 0) return r;
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    tc = (b5 + 8) >>> 4;

    // Pressure divisor, kept to 32 bits as the scheme does.
    b6   = b5 - 4000;
    b6sq = (b6 * b6) >>> 12;
    x1 = (b2 * b6sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = (ac1 * 4 + x3 + 2) >>> 2;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * b6sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    wide = 64'(ac4) * (64'(x3 + 32768) & 64'hFFFF_FFFF);
    b4 = wide[31:0] >> 15;
    if (b4 == 0) return r;

    // Scaled reading over the divisor, then the final correction.
    b7 = 32'(up - b3);
    wide = 64'(b7) * 64'd50000;
    b7 = wide[31:0];
    if (b7 < 32'h8000_0000) p = longint'((64'(b7) * 2) / 64'(b4));
    else p = longint'((64'(b7) / 64'(b4)) * 2);
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p  = p + ((x1 + x2 + 3791) >>> 4);

    if (tc > 32767) tc = 32767;
    if (tc < -32768) tc = -32768;
    if (p < 0) p = 0;
    if (p > 1048575) p = 1048575;
    r.temp   = tc[15:0];
    r.pascal = p[19:0];
    r.mmhg   = 17'((p * 3) / 40);
    r.fault  = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Calibration shadow, acceptance of beats and checking of results.
  always @(posedge clk) begin
    override_t ov;
    reading_t  want;
    if (rst_n) begin
      if (cfg_we && cfg_index <= bpc_pkg::CFG_MC_MD) cal[cfg_index] = cfg_wdata;
      if (start && !busy) begin
        ov = typed_results.pop_front();
        pending_readings.push_back(ov.typed ? ov.res
                                   : compensate(in_raw_temperature, in_raw_pressure));
        beats_in++;
      end
      if (out_valid) begin
        beats_out++;
        if (out_divide_fault) faults_seen++;
        if (pending_readings.size() == 0) begin
          report_mismatch("result beats against readings", beats_out, beats_in);
        end else begin
          want = pending_readings.pop_front();
          if (out_temperature_decidegrees !== want.temp)
            report_mismatch("temperature", out_temperature_decidegrees,
                            $signed(want.temp));
          if (out_pressure_pascal !== want.pascal)
            report_mismatch("pressure_pascal", out_pressure_pascal, want.pascal);
          if (out_pressure_mmhg_tenths !== want.mmhg)
            report_mismatch("pressure_mmhg", out_pressure_mmhg_tenths, want.mmhg);
          if (out_divide_fault !== want.fault)
            report_mismatch("divide_fault", out_divide_fault, want.fault);
        end
      end
    end
  end

  // Drives one reading pair from a falling edge and returns once it is taken.
  task automatic send_reading(bit [15:0] ut, bit [15:0] up, bit typed, reading_t res);
    int n;
    override_t ov;
    ov.typed = typed;
    ov.res   = res;
    typed_results.push_back(ov);
    n = beats_in;
    cfg_we             <= 1'b0;
    start              <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure    <= up;
    do @(negedge clk); while (beats_in == n);
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Sender holds off until every result is back and the pipeline is empty.
  task automatic drain();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_cal(logic [IDX_W-1:0] idx, bit [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Calibration from the sensor's published example, and nearby sets.
  localparam bit [31:0] NOMINAL [0:4] = '{32'h0198_FFB8, 32'hC7D1_7FE5,
                                         32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34};

  function automatic row_t wr_row(logic [IDX_W-1:0] idx, bit [31:0] data);
    row_t r;
    r = '{wr: 1'b1, idx: idx, data: data, default: '0};
    return r;
  endfunction

  function automatic row_t rd_row(bit [15:0] ut, bit [15:0] up, bit typed,
                                  reading_t res);
    row_t r;
    r = '{wr: 1'b0, ut: ut, up: up, typed: typed, res: res, default: '0};
    return r;
  endfunction

  initial begin
    row_t     table_rows [$];
    reading_t none;
    reading_t fault_res;
    bit       dirty;
    int       idle_pct [0:3];
    bit [15:0] ut, up;

    none      = '0;
    fault_res = '0;
    fault_res.fault = 1'b1;
    idle_pct  = '{0, 87, 0, 19};
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    faults_seen = 0;
    foreach (cal[i]) cal[i] = '0;

    start = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Zeroed calibration gives a zero temperature divisor.
    table_rows.push_back(rd_row(16'h0000, 16'h0000, 1, fault_res));
    table_rows.push_back(rd_row(16'hFFFF, 16'hFFFF, 1, fault_res));
    table_rows.push_back(wr_row(CFG_IDX_SPARE_LO, 32'hFFFF_FFFF));
    table_rows.push_back(wr_row(CFG_IDX_SPARE_HI, 32'h1234_5678));
    table_rows.push_back(rd_row(16'd1234, 16'd1, 1, fault_res));
    table_rows.push_back(wr_row(bpc_pkg::CFG_AC1_AC2, NOMINAL[0]));
    table_rows.push_back(wr_row(bpc_pkg::CFG_AC3_AC4, NOMINAL[1]));
    table_rows.push_back(wr_row(bpc_pkg::CFG_AC5_AC6, NOMINAL[2]));
    table_rows.push_back(wr_row(bpc_pkg::CFG_B1_B2, NOMINAL[3]));
    table_rows.push_back(wr_row(bpc_pkg::CFG_MC_MD, NOMINAL[4]));
    table_rows.push_back(rd_row(16'd27898, 16'd23843, 1,
                                '{temp: 16'd150, pascal: 20'd69964, mmhg: 17'd5247,
                                  fault: 1'b0}));
    table_rows.push_back(rd_row(16'h0000, 16'h0000, 0, none));
    table_rows.push_back(rd_row(16'hFFFF, 16'hFFFF, 0, none));
    table_rows.push_back(rd_row(16'hFFFF, 16'h0000, 0, none));
    table_rows.push_back(rd_row(16'h0000, 16'hFFFF, 0, none));
    // X1 equal to minus MD: AC5 of 32768 and AC6 of 0 make X1 equal UT.
    table_rows.push_back(wr_row(bpc_pkg::CFG_AC5_AC6, 32'h8000_0000));
    table_rows.push_back(wr_row(bpc_pkg::CFG_MC_MD, 32'hDDF9_FC18));
    table_rows.push_back(rd_row(16'd1000, 16'd23843, 1, fault_res));
    table_rows.push_back(rd_row(16'd1001, 16'd23843, 0, none));
    // AC4 of zero forces a zero pressure divisor.
    table_rows.push_back(wr_row(bpc_pkg::CFG_AC3_AC4, 32'hC7D1_0000));
    table_rows.push_back(rd_row(16'd27898, 16'd23843, 1, fault_res));
    // All calibration bits set, then the largest positive halves.
    for (int i = bpc_pkg::CFG_AC1_AC2; i <= bpc_pkg::CFG_MC_MD; i++)
      table_rows.push_back(wr_row(IDX_W'(i), 32'hFFFF_FFFF));
    table_rows.push_back(rd_row(16'hFFFF, 16'h0000, 0, none));
    table_rows.push_back(rd_row(16'h0000, 16'hFFFF, 0, none));
    for (int i = bpc_pkg::CFG_AC1_AC2; i <= bpc_pkg::CFG_MC_MD; i++)
      table_rows.push_back(wr_row(IDX_W'(i), 32'h7FFF_7FFF));
    table_rows.push_back(rd_row(16'h8000, 16'h8000, 0, none));
    table_rows.push_back(rd_row(16'h0001, 16'hFFFE, 0, none));

    dirty = 1'b0;
    foreach (table_rows[i]) begin
      if (table_rows[i].wr) begin
        if (dirty) drain();
        dirty = 1'b0;
        write_cal(table_rows[i].idx, table_rows[i].data);
      end else begin
        send_reading(table_rows[i].ut, table_rows[i].up, table_rows[i].typed,
                     table_rows[i].res);
        dirty = 1'b1;
      end
    end

    // Random phases: odd phases take fully random calibration.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int i = bpc_pkg::CFG_AC1_AC2; i <= bpc_pkg::CFG_MC_MD; i++)
        write_cal(IDX_W'(i), ph[0] ? $urandom() : NOMINAL[i] ^ ($urandom() & 32'h007F_007F));
      write_cal(CFG_IDX_SPARE_LO + 3'($urandom_range(2)), $urandom());
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(9) < 7) begin
          ut = 16'($urandom_range(35000, 20000));
          up = 16'($urandom_range(45000, 15000));
        end else begin
          ut = 16'($urandom());
          up = 16'($urandom());
        end
        // Stretches of back-to-back beats even in the idle phases.
        if (n % 64 >= 16) idle_gap(idle_pct[ph]);
        send_reading(ut, up, 1'b0, none);
      end
    end

    drain();
    $display("Readings accepted: %0d, results checked: %0d, divide faults: %0d",
             beats_in, beats_out, faults_seen);
    $display("Directed extremes, both divide faults and four random calibration phases.");
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### barometric_pressure_compensation_unit.f
rtl/bpc_pkg.sv
rtl/bpc_div.sv
rtl/barometric_pressure_compensation_unit.sv
test/barometric_pressure_compensation_unit_tb.sv
